FILE: hdl/bgr_pkg.sv
// Shared types, constants and helper functions of the bit group regrouper.
`default_nettype none

package bgr_pkg;

    localparam int SYM_W   = 8;
    localparam int WIDTH_W = 4;
    localparam int ACC_W   = 15;
    localparam int CFG_AW  = 2;
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    typedef logic [WIDTH_W-1:0] t_width;
    typedef logic [CFG_AW-1:0]  t_cfg_index;

    localparam t_cfg_index CFG_IN_WIDTH  = 2'd0;
    localparam t_cfg_index CFG_OUT_WIDTH = 2'd1;
    localparam t_cfg_index CFG_PAD_MODE  = 2'd2;

    localparam t_width RST_IN_WIDTH  = 4'd8;
    localparam t_width RST_OUT_WIDTH = 4'd5;
    localparam logic   RST_PAD_MODE  = 1'b1;

    // Effective widths after clamping, plus the padding mode.
    typedef struct packed {
        t_width iw;
        t_width ow;
        logic   pad;
    } t_cfg;

    // One queued item: symbol already masked to the input width.
    typedef struct packed {
        logic [SYM_W-1:0] sym;
        logic             last;
    } t_q_entry;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } t_bstate;

    function automatic t_width clamp_width(input t_width w);
        t_width r;
        if (w == 4'd0) begin
            r = 4'd1;
        end else if (w > 4'd8) begin
            r = 4'd8;
        end else begin
            r = w;
        end
        return r;
    endfunction

    // Mask with the low w bits set, w in 1..8.
    function automatic logic [SYM_W-1:0] width_mask(input t_width w);
        logic [SYM_W:0] m;
        m = ({{SYM_W{1'b0}}, 1'b1} << w) - {{SYM_W{1'b0}}, 1'b1};
        return m[SYM_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: hdl/bit_group_regrouper_core.sv
// Flow: the front end queues each input beat; the back end then merges the symbol into
// the accumulator, and each result it causes is registered at the output.
// The back end emits all results of a symbol before it merges the next one, and holds
// while the output stalls; the queue keeps taking input beats until it is full.
// Reset: registers return to in width 8, out width 5, pad mode; accumulator and queue empty.
// Top level of the bit group regrouper: configuration registers, front end and back end.
`default_nettype none

module bit_group_regrouper_core (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic [bgr_pkg::SYM_W-1:0]          i_symbol,
    input  wire logic                               i_stream_end,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic [bgr_pkg::SYM_W-1:0]               o_group,
    output logic                                    o_group_valid,
    output logic                                    o_run_last,
    output logic                                    o_closing,
    output logic                                    o_status,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire bgr_pkg::t_cfg_index                i_cfg_index,
    input  wire logic [bgr_pkg::WIDTH_W-1:0]        i_cfg_data
);

    bgr_pkg::t_width   r_in_width, r_out_width;
    logic              r_pad_mode;
    logic              cfg_wr, cfg_hit;
    bgr_pkg::t_cfg     cfg;
    logic              pop, q_valid;
    bgr_pkg::t_q_entry q_entry;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign cfg_hit     = cfg_wr && ((i_cfg_index == bgr_pkg::CFG_IN_WIDTH)
                                 || (i_cfg_index == bgr_pkg::CFG_OUT_WIDTH)
                                 || (i_cfg_index == bgr_pkg::CFG_PAD_MODE));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_width  <= bgr_pkg::RST_IN_WIDTH;
            r_out_width <= bgr_pkg::RST_OUT_WIDTH;
            r_pad_mode  <= bgr_pkg::RST_PAD_MODE;
        end else if (cfg_wr) begin
            unique case (i_cfg_index)
                bgr_pkg::CFG_IN_WIDTH:  r_in_width  <= i_cfg_data;
                bgr_pkg::CFG_OUT_WIDTH: r_out_width <= i_cfg_data;
                bgr_pkg::CFG_PAD_MODE:  r_pad_mode  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        cfg.iw  = bgr_pkg::clamp_width(r_in_width);
        cfg.ow  = bgr_pkg::clamp_width(r_out_width);
        cfg.pad = r_pad_mode;
    end

    bgr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_symbol     (i_symbol),
        .i_stream_end (i_stream_end),
        .i_cfg        (cfg),
        .i_pop        (pop),
        .o_q_valid    (q_valid),
        .o_q_entry    (q_entry)
    );

    bgr_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_clear       (cfg_hit),
        .i_q_valid     (q_valid),
        .i_q_entry     (q_entry),
        .o_pop         (pop),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_group       (o_group),
        .o_group_valid (o_group_valid),
        .o_run_last    (o_run_last),
        .o_closing     (o_closing),
        .o_status      (o_status)
    );

endmodule

`default_nettype wire

FILE: hdl/bgr_front.sv
// Front end: accepts input beats, masks the symbol and queues it for the back end.
`default_nettype none

module bgr_front (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic [bgr_pkg::SYM_W-1:0]    i_symbol,
    input  wire logic                         i_stream_end,
    input  wire bgr_pkg::t_cfg                i_cfg,
    input  wire logic                         i_pop,
    output logic                              o_q_valid,
    output bgr_pkg::t_q_entry                 o_q_entry
);

    bgr_pkg::t_q_entry            r_q [bgr_pkg::Q_DEPTH];
    logic [bgr_pkg::Q_AW-1:0]     r_wr_ptr, n_wr_ptr;
    logic [bgr_pkg::Q_AW-1:0]     r_rd_ptr, n_rd_ptr;
    logic [bgr_pkg::Q_AW:0]       r_count,  n_count;
    logic                         push;
    bgr_pkg::t_q_entry            entry;

    assign o_in_stall = (r_count == bgr_pkg::Q_AW'(0) + (bgr_pkg::Q_AW+1)'(bgr_pkg::Q_DEPTH));
    assign push       = i_in_valid && !o_in_stall;
    assign o_q_valid  = (r_count != '0);
    assign o_q_entry  = r_q[r_rd_ptr];

    always_comb begin
        entry.sym  = i_symbol & bgr_pkg::width_mask(i_cfg.iw);
        entry.last = i_stream_end;
    end

    always_comb begin
        n_wr_ptr = push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = i_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= entry;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/bgr_back.sv
// Back end: merges queued symbols into the accumulator and emits at most one group per beat.
`default_nettype none

module bgr_back (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire bgr_pkg::t_cfg                i_cfg,
    input  wire logic                         i_clear,
    input  wire logic                         i_q_valid,
    input  wire bgr_pkg::t_q_entry            i_q_entry,
    output logic                              o_pop,
    input  wire logic                         i_out_stall,
    output logic                              o_out_valid,
    output logic [bgr_pkg::SYM_W-1:0]         o_group,
    output logic                              o_group_valid,
    output logic                              o_run_last,
    output logic                              o_closing,
    output logic                              o_status
);

    bgr_pkg::t_bstate                 r_state, n_state;
    logic [bgr_pkg::ACC_W-1:0]        r_acc, n_acc;
    bgr_pkg::t_width                  r_pend, n_pend;
    logic                             r_last, n_last;

    logic                             r_out_valid;
    logic [bgr_pkg::SYM_W-1:0]        r_group;
    logic                             r_group_valid, r_run_last, r_closing, r_status;

    logic                             can_load, load;
    logic [bgr_pkg::SYM_W-1:0]        ld_group;
    logic                             ld_gv, ld_run_last, ld_closing, ld_status;

    logic [bgr_pkg::SYM_W-1:0]        omask;
    logic                             has_grp;
    bgr_pkg::t_width                  rem;
    logic [bgr_pkg::ACC_W+bgr_pkg::SYM_W-1:0] merge_sh;
    logic [bgr_pkg::ACC_W-1:0]        grp_sh;
    logic [bgr_pkg::ACC_W:0]          keep_mask;
    logic [bgr_pkg::ACC_W:0]          tail_sh;
    logic [bgr_pkg::SYM_W-1:0]        tail;

    assign omask     = bgr_pkg::width_mask(i_cfg.ow);
    assign has_grp   = (r_pend >= i_cfg.ow);
    assign rem       = r_pend - i_cfg.ow;
    assign merge_sh  = {{bgr_pkg::SYM_W{1'b0}}, r_acc} << i_cfg.iw;
    assign grp_sh    = r_acc >> rem;
    assign keep_mask = ({{bgr_pkg::ACC_W{1'b0}}, 1'b1} << rem)
                       - {{bgr_pkg::ACC_W{1'b0}}, 1'b1};
    // Pending bits sit right aligned; shifting them up fills the group from the top.
    assign tail_sh   = {1'b0, r_acc} << (i_cfg.ow - r_pend);
    assign tail      = tail_sh[bgr_pkg::SYM_W-1:0] & omask;
    assign can_load  = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_acc       = r_acc;
        n_pend      = r_pend;
        n_last      = r_last;
        o_pop       = 1'b0;
        load        = 1'b0;
        ld_group    = '0;
        ld_gv       = 1'b0;
        ld_run_last = 1'b0;
        ld_closing  = 1'b0;
        ld_status   = 1'b0;
        unique case (r_state)
            bgr_pkg::ST_IDLE: begin
                if (i_q_valid) begin
                    o_pop   = 1'b1;
                    n_acc   = merge_sh[bgr_pkg::ACC_W-1:0]
                              | {{(bgr_pkg::ACC_W-bgr_pkg::SYM_W){1'b0}}, i_q_entry.sym};
                    n_pend  = r_pend + i_cfg.iw;
                    n_last  = i_q_entry.last;
                    n_state = bgr_pkg::ST_EMIT;
                end
            end
            bgr_pkg::ST_EMIT: begin
                if (has_grp) begin
                    if (can_load) begin
                        load        = 1'b1;
                        ld_group    = grp_sh[bgr_pkg::SYM_W-1:0] & omask;
                        ld_gv       = 1'b1;
                        ld_run_last = (rem < i_cfg.ow) && !r_last;
                        n_pend      = rem;
                        n_acc       = r_acc & keep_mask[bgr_pkg::ACC_W-1:0];
                        if (ld_run_last) begin
                            n_state = bgr_pkg::ST_IDLE;
                        end
                    end
                end else if (r_last) begin
                    if (can_load) begin
                        load        = 1'b1;
                        ld_run_last = 1'b1;
                        ld_closing  = 1'b1;
                        if (i_cfg.pad) begin
                            ld_group = (r_pend != '0) ? tail : '0;
                            ld_gv    = (r_pend != '0);
                        end else begin
                            ld_status = (tail != '0) || (r_pend >= i_cfg.iw);
                        end
                        n_acc   = '0;
                        n_pend  = '0;
                        n_state = bgr_pkg::ST_IDLE;
                    end
                end else begin
                    // The symbol completed no group: nothing to deliver.
                    n_state = bgr_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bgr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bgr_pkg::ST_IDLE;
            r_acc       <= '0;
            r_pend      <= '0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_last  <= n_last;
            if (i_clear) begin
                r_acc  <= '0;
                r_pend <= '0;
            end else begin
                r_acc  <= n_acc;
                r_pend <= n_pend;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_group       <= ld_group;
            r_group_valid <= ld_gv;
            r_run_last    <= ld_run_last;
            r_closing     <= ld_closing;
            r_status      <= ld_status;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_group       = r_group;
    assign o_group_valid = r_group_valid;
    assign o_run_last    = r_run_last;
    assign o_closing     = r_closing;
    assign o_status      = r_status;

endmodule

`default_nettype wire

FILE: hdl/bgr_checker.sv
// Port-level checker for the bit group regrouper and its bind to the top level.
`default_nettype none

module bgr_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        o_out_valid,
    input wire logic                        i_out_stall,
    input wire logic [bgr_pkg::SYM_W-1:0]   o_group,
    input wire logic                        o_group_valid,
    input wire logic                        o_run_last,
    input wire logic                        o_closing,
    input wire logic                        o_status
);

    // A stalled result beat stays in place unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_group)
            && $stable(o_closing) && $stable(o_run_last) && $stable(o_status))
        else $error("result beat changed while stalled");

    // The closing beat always ends the results of its symbol.
    a_close_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_closing |-> o_run_last)
        else $error("closing beat without run_last");

    // Only a closing beat may report bad padding.
    a_status_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status |-> o_closing)
        else $error("status set on a non-closing beat");

    // Every ordinary beat carries a real group.
    a_group_real: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_closing |-> o_group_valid)
        else $error("ordinary beat without a group");

    // A padded tail group is never reported as bad padding.
    a_pad_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_closing && o_group_valid |-> !o_status)
        else $error("padded closing beat with error status");

endmodule

bind bit_group_regrouper_core bgr_checker u_bgr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_group       (o_group),
    .o_group_valid (o_group_valid),
    .o_run_last    (o_run_last),
    .o_closing     (o_closing),
    .o_status      (o_status)
);

`default_nettype wire
